[design/q2e_pkg.sv]
package q2e_pkg;

    // Fraction bits of the matrix terms; "1" is 2^28.
    localparam int WORK_FRAC = 28;
    // Width of one scaled product of two components.
    localparam int PROD_W = 30;
    // Width of a rotation-matrix term.
    localparam int TERM_W = 32;
    // Width of the sum of squares under the square root.
    localparam int SQ_W = 62;
    // Width of the square root; one root bit is found per cell.
    localparam int ROOT_W = SQ_W / 2;
    // Width of the remainder carried between root cells.
    localparam int REM_W = ROOT_W + 2;
    // CORDIC vector and angle widths.
    localparam int XW = 36;
    localparam int ZW = 34;
    // Number of entries in the arctangent table.
    localparam int ATAN_LEN = 24;

    // A quarter turn in angle units of 2^32 per turn.
    localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(64'sd1073741824);

    // atan(2^-i) in units of 2^32 per turn.
    localparam logic [30:0] ATAN_TAB [ATAN_LEN] = '{
        31'd536870912, 31'd316933406, 31'd167458907, 31'd85004756,
        31'd42667331,  31'd21354465,  31'd10679838,  31'd5340245,
        31'd2670163,   31'd1335087,   31'd667544,    31'd333772,
        31'd166886,    31'd83443,     31'd41722,     31'd20861,
        31'd10430,     31'd5215,      31'd2608,      31'd1304,
        31'd652,       31'd326,       31'd163,       31'd81
    };

    // Rotation-matrix terms that ride along the root chain.
    typedef struct packed {
        logic signed [TERM_W-1:0] m21;
        logic signed [TERM_W-1:0] m22;
        logic signed [TERM_W-1:0] m10;
        logic signed [TERM_W-1:0] m00;
        logic signed [TERM_W-1:0] m20;
    } terms_t;

    // State handed from one CORDIC cell to the next.
    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zero;
    } cordic_t;

    // Brings a vector into the right half plane and flags the zero vector.
    function automatic cordic_t prerot(input logic signed [XW-1:0] yi,
                                       input logic signed [XW-1:0] xi);
        cordic_t c;
        c.zero = (xi == '0) && (yi == '0);
        c.x = xi;
        c.y = yi;
        c.z = '0;
        if (xi < 0) begin
            if (yi >= 0) begin
                c.x = yi;
                c.y = -xi;
                c.z = QUARTER_TURN;
            end else begin
                c.x = -yi;
                c.y = xi;
                c.z = -QUARTER_TURN;
            end
        end
        return c;
    endfunction

endpackage

[design/q2e_root_cell.sv]
module q2e_root_cell (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [q2e_pkg::SQ_W-1:0]    n_in,
    input  logic [q2e_pkg::REM_W-1:0]   rem_in,
    input  logic [q2e_pkg::ROOT_W-1:0]  root_in,
    input  q2e_pkg::terms_t             terms_in,
    output logic [q2e_pkg::SQ_W-1:0]    n_out,
    output logic [q2e_pkg::REM_W-1:0]   rem_out,
    output logic [q2e_pkg::ROOT_W-1:0]  root_out,
    output q2e_pkg::terms_t             terms_out
);
    import q2e_pkg::*;

    logic [SQ_W-1:0]   n_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [REM_W-1:0]  rem_next;
    logic [ROOT_W-1:0] root_reg;
    logic [ROOT_W-1:0] root_next;
    terms_t            terms_reg;
    logic [REM_W+1:0]  rem_wide;
    logic [REM_W+1:0]  trial;

    // One restoring step: bring down two radicand bits and try a root bit of one.
    always_comb begin
        rem_wide = {rem_in, n_in[SQ_W-1:SQ_W-2]};
        trial    = (REM_W+2)'({root_in, 2'b01});
        if (rem_wide >= trial) begin
            rem_next  = REM_W'(rem_wide - trial);
            root_next = {root_in[ROOT_W-2:0], 1'b1};
        end else begin
            rem_next  = rem_wide[REM_W-1:0];
            root_next = {root_in[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg     <= {n_in[SQ_W-3:0], 2'b00};
            rem_reg   <= rem_next;
            root_reg  <= root_next;
            terms_reg <= terms_in;
        end
    end

    assign n_out     = n_reg;
    assign rem_out   = rem_reg;
    assign root_out  = root_reg;
    assign terms_out = terms_reg;

endmodule

[design/q2e_cordic_cell.sv]
module q2e_cordic_cell #(
    parameter int IDX = 0
) (
    input  logic               aclk,
    input  logic               en,
    input  q2e_pkg::cordic_t   c_in,
    output q2e_pkg::cordic_t   c_out
);
    import q2e_pkg::*;

    localparam logic signed [ZW-1:0] ATAN = ZW'(ATAN_TAB[IDX]);

    cordic_t            c_reg;
    cordic_t            c_next;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;

    // One vectoring micro-rotation toward the positive x axis.
    always_comb begin
        dx = c_in.y >>> IDX;
        dy = c_in.x >>> IDX;
        c_next.zero = c_in.zero;
        if (c_in.y >= 0) begin
            c_next.x = c_in.x + dx;
            c_next.y = c_in.y - dy;
            c_next.z = c_in.z + ATAN;
        end else begin
            c_next.x = c_in.x - dx;
            c_next.y = c_in.y + dy;
            c_next.z = c_in.z - ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_reg <= c_next;
        end
    end

    assign c_out = c_reg;

endmodule

[design/quaternion_to_euler_angles.sv]
// Quaternion to roll, pitch and yaw (Z-Y-X Euler angles).
// Input channel s_*: one quaternion per transfer, four signed 16-bit fields
// w, x, y, z; the low QUAT_BITS bits of each are used as a signed fraction.
// Output channel m_*: one result per transfer, roll, pitch and yaw as 16-bit
// binary angles (LSB pi/32768, -32768 is -pi); pitch stays in [-16384, 16384].
// Throughput is one quaternion per cycle while the receiver keeps up. From
// the input transfer to m_tvalid a quaternion passes four product and term
// stages, one cell per root bit of the 31-bit square root, a quadrant stage,
// one cell per CORDIC stage, and the output register.
// The whole pipeline moves together. Behind the output register sits a skid
// register: when the receiver stalls, one more result lands there, s_tready
// drops, and the pipeline holds until the receiver takes a result.
// Reset (aresetn low at a clock edge) empties the pipeline and both output
// registers; no result in flight survives it.
module quaternion_to_euler_angles #(
    parameter int CORDIC_STAGES = 16,
    parameter int QUAT_BITS     = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // quat_w, quat_x, quat_y, quat_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // roll_angle, pitch_angle, yaw_angle
);
    import q2e_pkg::*;

    localparam int PROD_FRAC = 2 * (QUAT_BITS - 1);
    localparam int SHL = (WORK_FRAC > PROD_FRAC) ? WORK_FRAC - PROD_FRAC : 0;
    localparam int SHR = (PROD_FRAC > WORK_FRAC) ? PROD_FRAC - WORK_FRAC : 0;
    localparam int DEPTH = 5 + ROOT_W + CORDIC_STAGES;
    localparam logic signed [TERM_W-1:0] ONE = TERM_W'(64'sd1 << WORK_FRAC);

    // Product of two components, scaled to the working fraction.
    function automatic logic signed [PROD_W-1:0] prod(
        input logic signed [QUAT_BITS-1:0] a,
        input logic signed [QUAT_BITS-1:0] b);
        logic signed [2*QUAT_BITS-1:0] p;
        logic signed [63:0]            e;
        p = a * b;
        e = 64'(p);
        e = (e <<< SHL) >>> SHR;
        return e[PROD_W-1:0];
    endfunction

    // Rounds a CORDIC angle to a binary angle.
    function automatic logic signed [ZW-1:0] to_bam(input cordic_t c);
        logic signed [ZW-1:0] s;
        s = c.z + ZW'(32768);
        s = s >>> 16;
        if (c.zero) begin
            s = '0;
        end
        return s;
    endfunction

    logic en;
    logic [DEPTH-1:0] vld_reg;

    // Component selection from the input word.
    logic [47:0] zw, zx, zy, zz;
    logic signed [QUAT_BITS-1:0] qw, qx, qy, qz;
    assign zw = {32'b0, s_tdata[15:0]};
    assign zx = {32'b0, s_tdata[31:16]};
    assign zy = {32'b0, s_tdata[47:32]};
    assign zz = {32'b0, s_tdata[63:48]};
    assign qw = $signed(zw[QUAT_BITS-1:0]);
    assign qx = $signed(zx[QUAT_BITS-1:0]);
    assign qy = $signed(zy[QUAT_BITS-1:0]);
    assign qz = $signed(zz[QUAT_BITS-1:0]);

    // Stage 1: the nine component products.
    logic signed [PROD_W-1:0] yz_reg, wx_reg, xx_reg, yy_reg, xy_reg;
    logic signed [PROD_W-1:0] wz_reg, zz_reg, xz_reg, wy_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            yz_reg <= prod(qy, qz);
            wx_reg <= prod(qw, qx);
            xx_reg <= prod(qx, qx);
            yy_reg <= prod(qy, qy);
            xy_reg <= prod(qx, qy);
            wz_reg <= prod(qw, qz);
            zz_reg <= prod(qz, qz);
            xz_reg <= prod(qx, qz);
            wy_reg <= prod(qw, qy);
        end
    end

    // Stage 2: the rotation-matrix terms.
    terms_t t2_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            t2_reg.m21 <= (TERM_W'(yz_reg) + TERM_W'(wx_reg)) <<< 1;
            t2_reg.m22 <= ONE - ((TERM_W'(xx_reg) + TERM_W'(yy_reg)) <<< 1);
            t2_reg.m10 <= (TERM_W'(xy_reg) + TERM_W'(wz_reg)) <<< 1;
            t2_reg.m00 <= ONE - ((TERM_W'(yy_reg) + TERM_W'(zz_reg)) <<< 1);
            t2_reg.m20 <= (TERM_W'(xz_reg) - TERM_W'(wy_reg)) <<< 1;
        end
    end

    // Stage 3: squares of the roll terms' magnitudes.
    logic signed [TERM_W-1:0] abs21, abs22;
    logic [ROOT_W-1:0] a21, a22;
    logic [SQ_W-1:0] s21_reg, s22_reg;
    terms_t t3_reg;
    assign abs21 = (t2_reg.m21 < 0) ? -t2_reg.m21 : t2_reg.m21;
    assign abs22 = (t2_reg.m22 < 0) ? -t2_reg.m22 : t2_reg.m22;
    assign a21 = abs21[ROOT_W-1:0];
    assign a22 = abs22[ROOT_W-1:0];
    always_ff @(posedge aclk) begin
        if (en) begin
            s21_reg <= a21 * a21;
            s22_reg <= a22 * a22;
            t3_reg  <= t2_reg;
        end
    end

    // Stage 4: sum of squares.
    logic [SQ_W-1:0] sum_reg;
    terms_t t4_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg <= s21_reg + s22_reg;
            t4_reg  <= t3_reg;
        end
    end

    // Square-root chain, one root bit per cell.
    logic [SQ_W-1:0]   rn   [ROOT_W+1];
    logic [REM_W-1:0]  rrem [ROOT_W+1];
    logic [ROOT_W-1:0] rrt  [ROOT_W+1];
    terms_t            rtm  [ROOT_W+1];
    assign rn[0]   = sum_reg;
    assign rrem[0] = '0;
    assign rrt[0]  = '0;
    assign rtm[0]  = t4_reg;
    for (genvar k = 0; k < ROOT_W; k++) begin : g_root
        q2e_root_cell u_cell (
            .aclk      (aclk),
            .en        (en),
            .n_in      (rn[k]),
            .rem_in    (rrem[k]),
            .root_in   (rrt[k]),
            .terms_in  (rtm[k]),
            .n_out     (rn[k+1]),
            .rem_out   (rrem[k+1]),
            .root_out  (rrt[k+1]),
            .terms_out (rtm[k+1])
        );
    end

    // Quadrant stage for the three angle pipelines.
    cordic_t pr_reg, pp_reg, py_reg;
    terms_t  tq;
    assign tq = rtm[ROOT_W];
    always_ff @(posedge aclk) begin
        if (en) begin
            pr_reg <= prerot(XW'(tq.m21), XW'(tq.m22));
            py_reg <= prerot(XW'(tq.m10), XW'(tq.m00));
            pp_reg <= prerot(-XW'(tq.m20), XW'(rrt[ROOT_W]));
        end
    end

    // Three CORDIC chains side by side.
    cordic_t cr [CORDIC_STAGES+1];
    cordic_t cp [CORDIC_STAGES+1];
    cordic_t cy [CORDIC_STAGES+1];
    assign cr[0] = pr_reg;
    assign cp[0] = pp_reg;
    assign cy[0] = py_reg;
    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
        q2e_cordic_cell #(.IDX(i)) u_roll (
            .aclk(aclk), .en(en), .c_in(cr[i]), .c_out(cr[i+1]));
        q2e_cordic_cell #(.IDX(i)) u_pitch (
            .aclk(aclk), .en(en), .c_in(cp[i]), .c_out(cp[i+1]));
        q2e_cordic_cell #(.IDX(i)) u_yaw (
            .aclk(aclk), .en(en), .c_in(cy[i]), .c_out(cy[i+1]));
    end

    // Final rounding and pitch clamp.
    logic signed [ZW-1:0] roll_b, pitch_b, yaw_b, pitch_c;
    logic [47:0] result;
    always_comb begin
        roll_b  = to_bam(cr[CORDIC_STAGES]);
        pitch_b = to_bam(cp[CORDIC_STAGES]);
        yaw_b   = to_bam(cy[CORDIC_STAGES]);
        pitch_c = pitch_b;
        if (pitch_b > ZW'(16384)) begin
            pitch_c = ZW'(16384);
        end else if (pitch_b < -ZW'(16384)) begin
            pitch_c = -ZW'(16384);
        end
        result = {yaw_b[15:0], pitch_c[15:0], roll_b[15:0]};
    end

    // Valid bits travel with the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[DEPTH-2:0], s_tvalid};
        end
    end

    // Output register with a skid register behind it.
    logic        out_v_reg, skid_v_reg;
    logic [47:0] out_reg, skid_reg;
    logic        take, arrive;
    assign en     = !skid_v_reg;
    assign take   = out_v_reg && m_tready;
    assign arrive = en && vld_reg[DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else if (skid_v_reg) begin
            if (take) begin
                skid_v_reg <= 1'b0;
            end
        end else if (arrive) begin
            if (out_v_reg && !take) begin
                skid_v_reg <= 1'b1;
            end else begin
                out_v_reg <= 1'b1;
            end
        end else if (take) begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_v_reg) begin
            if (take) begin
                out_reg <= skid_reg;
            end
        end else if (arrive) begin
            if (out_v_reg && !take) begin
                skid_reg <= result;
            end else begin
                out_reg <= result;
            end
        end
    end

    assign s_tready = en;
    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_reg;

endmodule

[design/q2e_checker.sv]
module q2e_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);

    // Reset empties the output side.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("output not empty after reset");

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Input back-pressure only while a result is waiting.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result waiting");

    // Taking a result while stalled frees the input side.
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !s_tready |=> s_tready && m_tvalid)
        else $error("skid register did not drain");

    // Pitch stays within a quarter turn.
    a_pitch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[31:16]) <= 16'sd16384) &&
                     ($signed(m_tdata[31:16]) >= -16'sd16384))
        else $error("pitch out of range");

endmodule

bind quaternion_to_euler_angles q2e_checker u_q2e_checker (.*);
